### rtl/mccc_pkg.sv
`timescale 1ns / 1ps

package mccc_pkg;

	localparam int unsigned DATA_W = 16;
	localparam int unsigned PROD_W = 2 * DATA_W;

	localparam logic [DATA_W-1:0] PERMILLE = 16'd1000;

	localparam logic [2:0] REQ_START = 3'd0;
	localparam logic [2:0] REQ_STOP  = 3'd1;
	localparam logic [2:0] REQ_SET   = 3'd2;
	localparam logic [2:0] REQ_POLL  = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;

	localparam logic [2:0] CFG_SENSE    = 3'd0;
	localparam logic [2:0] CFG_VREF_FS  = 3'd1;
	localparam logic [2:0] CFG_DAC_FULL = 3'd2;
	localparam logic [2:0] CFG_CUR_MAX  = 3'd3;
	localparam logic [2:0] CFG_CUR_MIN  = 3'd4;

	localparam logic [DATA_W-1:0] RST_SENSE    = 16'd100;
	localparam logic [DATA_W-1:0] RST_VREF_FS  = 16'd3300;
	localparam logic [DATA_W-1:0] RST_DAC_FULL = 16'd4095;
	localparam logic [DATA_W-1:0] RST_CUR_MAX  = 16'd2000;
	localparam logic [DATA_W-1:0] RST_CUR_MIN  = 16'd100;

	typedef struct packed {
		logic busy;
		logic done;
	} ser_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_MV,
		ST_DIV_MV,
		ST_MUL_CODE,
		ST_DIV_CODE,
		ST_DEM_MUL,
		ST_DEM_DIV,
		ST_FIN
	} state_t;

endpackage

### rtl/mccc_mul.sv
`timescale 1ns / 1ps

module mccc_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mccc_pkg::DATA_W-1:0]     a,
	input  logic [mccc_pkg::DATA_W-1:0]     b,
	output logic [mccc_pkg::PROD_W-1:0]     prod,
	output mccc_pkg::ser_stat_t             stat
);
	import mccc_pkg::*;

	logic [DATA_W-1:0] a_q;
	logic [PROD_W-1:0] prod_q;
	logic [3:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W:0]   sum;

	assign sum = {1'b0, prod_q[PROD_W-1:DATA_W]} + (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 4'd15);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{DATA_W{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[DATA_W-1:1]};
		end
	end

	assign prod      = prod_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### rtl/mccc_div.sv
`timescale 1ns / 1ps

module mccc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mccc_pkg::PROD_W-1:0]     num,
	input  logic [mccc_pkg::DATA_W-1:0]     den,
	output logic [mccc_pkg::PROD_W-1:0]     quot,
	output mccc_pkg::ser_stat_t             stat
);
	import mccc_pkg::*;

	logic [PROD_W-1:0] n_q;
	logic [DATA_W-1:0] d_q;
	logic [DATA_W-1:0] rem_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W:0]   r;
	logic [DATA_W:0]   diff;
	logic              ge;

	assign r    = {rem_q, n_q[PROD_W-1]};
	assign diff = r - {1'b0, d_q};
	assign ge   = r >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_W-1:0] : r[DATA_W-1:0];
			n_q   <= {n_q[PROD_W-2:0], ge};
		end
	end

	assign quot      = n_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### rtl/motor_current_command_controller.sv
`timescale 1ns / 1ps
// Motor driver command block.
// Input channel (in_valid/in_ready) carries one command: start, stop, set current,
// poll or clear fault, with its current request and poll samples. Each command
// gives exactly one result on the output channel (out_valid/out_ready): drive pins,
// fault flag, status, stored speed, commanded current, DAC code and demand.
// Configuration registers are written through cfg_we/cfg_index/cfg_data, one
// register per cycle; the user must write them only while no command is in flight,
// which the block itself does not enforce. Arithmetic runs on one bit-serial
// shift-add multiplier and one bit-serial restoring divider, shared in sequence.
// A set current with the driver enabled and no fault runs three multiply/divide
// pairs; every other command runs only the demand pair. One command is processed
// at a time; in_ready is high while the sequencer is idle, so the next command is
// taken in the cycle after the result is loaded at the earliest.
// The result waits in an output register; the next command is taken while it is
// unclaimed, and the sequencer holds at its last step if the receiver stalls.
// Reset loads the default configuration, disables the driver, sets brake and
// forward, clears fault, current, speed and DAC code, and empties the output.
module motor_current_command_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [15:0] current_ma,
	input  logic        diag_active,
	input  logic        tacho_valid,
	input  logic [15:0] tacho_rpm,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [15:0] vref_code,
	output logic        enable_pin,
	output logic        brake_pin,
	output logic        forward_pin,
	output logic        fault_flag,
	output logic [15:0] speed_rpm,
	output logic [9:0]  demand_permille,
	output logic [15:0] commanded_current_ma
);
	import mccc_pkg::*;

	state_t state_q, state_nx;

	logic [DATA_W-1:0] sense_q, vfs_q, dac_full_q, max_q, min_q;
	logic              en_q, fault_q, brake_q, fwd_q, status_q;
	logic [DATA_W-1:0] cmd_q, rpm_q, dac_q;
	logic [9:0]        dem_q;

	logic              mul_start_q, div_start_q;
	logic [DATA_W-1:0] mul_a_q, mul_b_q, div_d_q;
	logic [PROD_W-1:0] div_n_q;
	logic [PROD_W-1:0] mul_prod, div_quot;
	ser_stat_t         mul_st, div_st;

	logic              out_valid_q;
	logic              out_status_q, out_en_q, out_brake_q, out_fwd_q, out_fault_q;
	logic [DATA_W-1:0] out_vref_q, out_rpm_q, out_cmd_q;
	logic [9:0]        out_dem_q;

	logic              accept, out_load, set_ok;
	logic [DATA_W-1:0] ma_hi, ma_cl, cmd_nx, mv_cl, code_cl;
	logic [9:0]        dem_cl;

	mccc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.prod   (mul_prod),
		.stat   (mul_st)
	);

	mccc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_n_q),
		.den    (div_d_q),
		.quot   (div_quot),
		.stat   (div_st)
	);

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		accept   = in_valid && in_ready;
		out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = set_ok ? ST_MUL_MV : ST_DEM_MUL;
				end
			end
			ST_MUL_MV:   if (mul_st.done) state_nx = ST_DIV_MV;
			ST_DIV_MV:   if (div_st.done) state_nx = ST_MUL_CODE;
			ST_MUL_CODE: if (mul_st.done) state_nx = ST_DIV_CODE;
			ST_DIV_CODE: if (div_st.done) state_nx = ST_DEM_MUL;
			ST_DEM_MUL:  if (mul_st.done) state_nx = ST_DEM_DIV;
			ST_DEM_DIV:  if (div_st.done) state_nx = ST_FIN;
			ST_FIN:      if (out_load) state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		set_ok = (req_type == REQ_SET) && en_q && !fault_q;
		ma_hi  = (current_ma > max_q) ? max_q : current_ma;
		ma_cl  = ((ma_hi != '0) && (ma_hi < min_q)) ? min_q : ma_hi;
		cmd_nx = cmd_q;
		unique case (req_type)
			REQ_START: if (!fault_q) cmd_nx = '0;
			REQ_STOP:  cmd_nx = '0;
			REQ_SET:   cmd_nx = set_ok ? ma_cl : '0;
			REQ_POLL:  if (diag_active) cmd_nx = '0;
			default:   cmd_nx = cmd_q;
		endcase
		mv_cl   = (div_quot > {{DATA_W{1'b0}}, vfs_q}) ? vfs_q : div_quot[DATA_W-1:0];
		code_cl = (vfs_q == '0) ? '0 :
			(div_quot > {{DATA_W{1'b0}}, dac_full_q}) ? dac_full_q : div_quot[DATA_W-1:0];
		dem_cl  = (max_q == '0) ? '0 :
			(div_quot > {{DATA_W{1'b0}}, PERMILLE}) ? PERMILLE[9:0] : div_quot[9:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sense_q    <= RST_SENSE;
			vfs_q      <= RST_VREF_FS;
			dac_full_q <= RST_DAC_FULL;
			max_q      <= RST_CUR_MAX;
			min_q      <= RST_CUR_MIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SENSE:    sense_q    <= cfg_data;
				CFG_VREF_FS:  vfs_q      <= cfg_data;
				CFG_DAC_FULL: dac_full_q <= cfg_data;
				CFG_CUR_MAX:  max_q      <= cfg_data;
				CFG_CUR_MIN:  min_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= 1'b0;
			fault_q     <= 1'b0;
			brake_q     <= 1'b1;
			fwd_q       <= 1'b1;
			status_q    <= 1'b0;
			cmd_q       <= '0;
			rpm_q       <= '0;
			dac_q       <= '0;
			dem_q       <= '0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			div_n_q     <= '0;
			div_d_q     <= '0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q    <= (req_type == REQ_START) && fault_q;
						cmd_q       <= cmd_nx;
						mul_a_q     <= cmd_nx;
						mul_b_q     <= set_ok ? sense_q : PERMILLE;
						mul_start_q <= 1'b1;
						unique case (req_type)
							REQ_START: begin
								if (!fault_q) begin
									dac_q   <= '0;
									fwd_q   <= 1'b1;
									brake_q <= 1'b0;
									en_q    <= 1'b1;
								end
							end
							REQ_STOP: begin
								dac_q   <= '0;
								en_q    <= 1'b0;
								brake_q <= 1'b1;
							end
							REQ_SET: begin
								if (!set_ok) begin
									dac_q <= '0;
								end
							end
							REQ_POLL: begin
								if (diag_active) begin
									fault_q <= 1'b1;
									dac_q   <= '0;
									en_q    <= 1'b0;
								end
								if (tacho_valid) begin
									rpm_q <= tacho_rpm;
								end
							end
							REQ_CLEAR: fault_q <= 1'b0;
							default: ;
						endcase
					end
				end
				ST_MUL_MV: begin
					if (mul_st.done) begin
						div_n_q     <= mul_prod;
						div_d_q     <= PERMILLE;
						div_start_q <= 1'b1;
					end
				end
				ST_DIV_MV: begin
					if (div_st.done) begin
						mul_a_q     <= mv_cl;
						mul_b_q     <= dac_full_q;
						mul_start_q <= 1'b1;
					end
				end
				ST_MUL_CODE: begin
					if (mul_st.done) begin
						div_n_q     <= mul_prod;
						div_d_q     <= vfs_q;
						div_start_q <= 1'b1;
					end
				end
				ST_DIV_CODE: begin
					if (div_st.done) begin
						dac_q       <= code_cl;
						mul_a_q     <= cmd_q;
						mul_b_q     <= PERMILLE;
						mul_start_q <= 1'b1;
					end
				end
				ST_DEM_MUL: begin
					if (mul_st.done) begin
						div_n_q     <= mul_prod;
						div_d_q     <= max_q;
						div_start_q <= 1'b1;
					end
				end
				ST_DEM_DIV: begin
					if (div_st.done) begin
						dem_q <= dem_cl;
					end
				end
				ST_FIN: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_vref_q   <= dac_q;
			out_en_q     <= en_q;
			out_brake_q  <= brake_q;
			out_fwd_q    <= fwd_q;
			out_fault_q  <= fault_q;
			out_rpm_q    <= rpm_q;
			out_dem_q    <= dem_q;
			out_cmd_q    <= cmd_q;
		end
	end

	assign out_valid            = out_valid_q;
	assign status               = out_status_q;
	assign vref_code            = out_vref_q;
	assign enable_pin           = out_en_q;
	assign brake_pin            = out_brake_q;
	assign forward_pin          = out_fwd_q;
	assign fault_flag           = out_fault_q;
	assign speed_rpm            = out_rpm_q;
	assign demand_permille      = out_dem_q;
	assign commanded_current_ma = out_cmd_q;

	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mul_st.busy && !div_st.busy && !mul_st.done && !div_st.done)
		else $error("arithmetic unit active while idle");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_st.done |-> (state_q == ST_MUL_MV || state_q == ST_MUL_CODE ||
			state_q == ST_DEM_MUL))
		else $error("multiply finished outside a multiply step");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ST_DIV_MV || state_q == ST_DIV_CODE ||
			state_q == ST_DEM_DIV))
		else $error("divide finished outside a divide step");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_st.busy && div_st.busy))
		else $error("multiplier and divider busy together");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid && state_q == ST_IDLE)
		else $error("result not presented after final step");

endmodule

### verif/motor_current_command_controller_tb.sv
`timescale 1ns / 1ps

module motor_current_command_controller_tb;

	import mccc_pkg::*;

	localparam logic [2:0] REQ_SPARE_LO = REQ_CLEAR + 3'd1;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_ITEMS = 200;
	localparam int TAIL_CYCLES = 200;

	typedef struct packed {
		logic [2:0]  req;
		logic [15:0] ma;
		logic        diag;
		logic        tvalid;
		logic [15:0] rpm;
	} command_t;

	typedef struct packed {
		logic        status;
		logic [15:0] vref;
		logic        enable;
		logic        brake;
		logic        forward;
		logic        fault;
		logic [15:0] speed;
		logic [9:0]  demand;
		logic [15:0] cmd_ma;
	} drive_report_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  req_type;
	logic [15:0] current_ma;
	logic        diag_active;
	logic        tacho_valid;
	logic [15:0] tacho_rpm;
	logic        out_valid;
	logic        out_ready;
	logic        status;
	logic [15:0] vref_code;
	logic        enable_pin;
	logic        brake_pin;
	logic        forward_pin;
	logic        fault_flag;
	logic [15:0] speed_rpm;
	logic [9:0]  demand_permille;
	logic [15:0] commanded_current_ma;

	// configuration shadow
	logic [15:0] sense_mohm;
	logic [15:0] vref_fs_mv;
	logic [15:0] dac_full;
	logic [15:0] cur_max_ma;
	logic [15:0] cur_min_ma;

	// predicted driver state
	logic        drv_enabled;
	logic        drv_fault;
	logic        drv_brake;
	logic        drv_forward;
	logic [15:0] drv_cmd_ma;
	logic [15:0] drv_rpm;
	logic [15:0] drv_dac;

	command_t      pending_cmds[$];
	drive_report_t pending_reports[$];
	command_t      on_bus;
	drive_report_t seen_report;
	drive_report_t due_report;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int queued_count = 0;
	int mismatch_count = 0;
	int quiet_cycles;

	motor_current_command_controller u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.req_type            (req_type),
		.current_ma          (current_ma),
		.diag_active         (diag_active),
		.tacho_valid         (tacho_valid),
		.tacho_rpm           (tacho_rpm),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.status              (status),
		.vref_code           (vref_code),
		.enable_pin          (enable_pin),
		.brake_pin           (brake_pin),
		.forward_pin         (forward_pin),
		.fault_flag          (fault_flag),
		.speed_rpm           (speed_rpm),
		.demand_permille     (demand_permille),
		.commanded_current_ma(commanded_current_ma)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] dac_for_current(input logic [15:0] ma);
		logic [31:0] mv;
		logic [31:0] code;
		mv = (32'(ma) * 32'(sense_mohm)) / 32'(PERMILLE);
		if (mv > 32'(vref_fs_mv)) mv = 32'(vref_fs_mv);
		if (vref_fs_mv == '0) return '0;
		code = (mv * 32'(dac_full)) / 32'(vref_fs_mv);
		if (code > 32'(dac_full)) code = 32'(dac_full);
		return code[15:0];
	endfunction

	function automatic logic [9:0] demand_of_command();
		logic [31:0] s;
		if (cur_max_ma == '0) return '0;
		s = (32'(drv_cmd_ma) * 32'(PERMILLE)) / 32'(cur_max_ma);
		if (s > 32'(PERMILLE)) s = 32'(PERMILLE);
		return s[9:0];
	endfunction

	function automatic drive_report_t apply_command(input command_t c);
		drive_report_t r;
		logic [15:0] ma;
		r = '0;
		ma = c.ma;
		case (c.req)
			REQ_START: begin
				if (drv_fault) begin
					r.status = 1'b1;
				end else begin
					drv_dac = '0;
					drv_forward = 1'b1;
					drv_brake = 1'b0;
					drv_enabled = 1'b1;
					drv_cmd_ma = '0;
				end
			end
			REQ_STOP: begin
				drv_dac = '0;
				drv_enabled = 1'b0;
				drv_brake = 1'b1;
				drv_cmd_ma = '0;
			end
			REQ_SET: begin
				if (!drv_enabled || drv_fault) begin
					drv_cmd_ma = '0;
					drv_dac = '0;
				end else begin
					if (ma > cur_max_ma) ma = cur_max_ma;
					if (ma != '0 && ma < cur_min_ma) ma = cur_min_ma;
					drv_cmd_ma = ma;
					drv_dac = dac_for_current(ma);
				end
			end
			REQ_POLL: begin
				if (c.diag) begin
					drv_fault = 1'b1;
					drv_dac = '0;
					drv_enabled = 1'b0;
					drv_cmd_ma = '0;
				end
				if (c.tvalid) drv_rpm = c.rpm;
			end
			REQ_CLEAR: begin
				drv_fault = 1'b0;
			end
			default: begin
			end
		endcase
		r.vref = drv_dac;
		r.enable = drv_enabled;
		r.brake = drv_brake;
		r.forward = drv_forward;
		r.fault = drv_fault;
		r.speed = drv_rpm;
		r.demand = demand_of_command();
		r.cmd_ma = drv_cmd_ma;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned expv,
			input int unsigned gotv);
		mismatch_count++;
		$display("%0t ERROR %s: expected %0d, got %0d", $time, what, expv, gotv);
	endtask

	task automatic check_field(input string what, input int unsigned expv,
			input int unsigned gotv);
		if (expv != gotv) report_mismatch(what, expv, gotv);
	endtask

	task automatic push_cmd(input logic [2:0] req, input logic [15:0] ma, input logic diag,
			input logic tvalid, input logic [15:0] rpm);
		command_t c;
		c.req = req;
		c.ma = ma;
		c.diag = diag;
		c.tvalid = tvalid;
		c.rpm = rpm;
		pending_cmds.push_back(c);
		queued_count++;
	endtask

	function automatic logic [15:0] pick_current();
		int v;
		v = 0;
		case ($urandom_range(5))
			0: v = $urandom_range(65535);
			1: v = $urandom_range(300);
			2: v = int'(cur_min_ma) + int'($urandom_range(6)) - 3;
			3: v = int'(cur_max_ma) + int'($urandom_range(6)) - 3;
			4: v = $urandom_range(1) ? 65535 : 0;
			default: v = $urandom_range(4000);
		endcase
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return 16'(v);
	endfunction

	// start, a run of set, poll, clear, random-type and fault-recovery commands, then possibly a stop and a spare command
	task automatic random_session();
		int n;
		int pick;
		push_cmd(REQ_START, 16'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
		n = $urandom_range(10, 1);
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				push_cmd(REQ_SET, pick_current(), 1'($urandom), 1'($urandom), 16'($urandom));
			end else if (pick < 85) begin
				push_cmd(REQ_POLL, 16'($urandom), 1'b0, 1'($urandom), 16'($urandom));
			end else if (pick < 90) begin
				push_cmd(REQ_POLL, 16'($urandom), 1'b1, 1'($urandom), 16'($urandom));
				push_cmd(REQ_START, 16'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
				push_cmd(REQ_SET, pick_current(), 1'($urandom), 1'($urandom), 16'($urandom));
				push_cmd(REQ_CLEAR, 16'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
				push_cmd(REQ_START, 16'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
			end else if (pick < 95) begin
				push_cmd(3'($urandom_range(REQ_SPARE_HI)), 16'($urandom), 1'($urandom),
					1'($urandom), 16'($urandom));
			end else begin
				push_cmd(REQ_CLEAR, 16'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
			end
		end
		if ($urandom_range(3) == 0)
			push_cmd(REQ_STOP, 16'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
		if ($urandom_range(7) == 0)
			push_cmd(3'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO)), 16'($urandom),
				1'($urandom), 1'($urandom), 16'($urandom));
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_SENSE:    sense_mohm = val;
			CFG_VREF_FS:  vref_fs_mv = val;
			CFG_DAC_FULL: dac_full = val;
			CFG_CUR_MAX:  cur_max_ma = val;
			CFG_CUR_MIN:  cur_min_ma = val;
			default: begin
			end
		endcase
	endtask

	task automatic apply_settings(input logic [15:0] s, input logic [15:0] v,
			input logic [15:0] d, input logic [15:0] mx, input logic [15:0] mn);
		write_register(CFG_SENSE, s);
		write_register(CFG_VREF_FS, v);
		write_register(CFG_DAC_FULL, d);
		write_register(CFG_CUR_MAX, mx);
		write_register(CFG_CUR_MIN, mn);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || in_valid || pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= '0;
			current_ma <= '0;
			diag_active <= 1'b0;
			tacho_valid <= 1'b0;
			tacho_rpm <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) pending_reports.push_back(apply_command(on_bus));
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				on_bus = pending_cmds.pop_front();
				in_valid <= 1'b1;
				req_type <= on_bus.req;
				current_ma <= on_bus.ma;
				diag_active <= on_bus.diag;
				tacho_valid <= on_bus.tvalid;
				tacho_rpm <= on_bus.rpm;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				seen_report.status = status;
				seen_report.vref = vref_code;
				seen_report.enable = enable_pin;
				seen_report.brake = brake_pin;
				seen_report.forward = forward_pin;
				seen_report.fault = fault_flag;
				seen_report.speed = speed_rpm;
				seen_report.demand = demand_permille;
				seen_report.cmd_ma = commanded_current_ma;
				if (pending_reports.size() == 0) begin
					report_mismatch("result with no command pending", 0, 1);
				end else begin
					due_report = pending_reports.pop_front();
					check_field("status", 32'(due_report.status), 32'(seen_report.status));
					check_field("vref_code", 32'(due_report.vref), 32'(seen_report.vref));
					check_field("enable_pin", 32'(due_report.enable),
						32'(seen_report.enable));
					check_field("brake_pin", 32'(due_report.brake), 32'(seen_report.brake));
					check_field("forward_pin", 32'(due_report.forward),
						32'(seen_report.forward));
					check_field("fault_flag", 32'(due_report.fault), 32'(seen_report.fault));
					check_field("speed_rpm", 32'(due_report.speed), 32'(seen_report.speed));
					check_field("demand_permille", 32'(due_report.demand),
						32'(seen_report.demand));
					check_field("commanded_current_ma", 32'(due_report.cmd_ma),
						32'(seen_report.cmd_ma));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("motor_current_command_controller verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		sense_mohm = RST_SENSE;
		vref_fs_mv = RST_VREF_FS;
		dac_full = RST_DAC_FULL;
		cur_max_ma = RST_CUR_MAX;
		cur_min_ma = RST_CUR_MIN;
		drv_enabled = 1'b0;
		drv_fault = 1'b0;
		drv_brake = 1'b1;
		drv_forward = 1'b1;
		drv_cmd_ma = '0;
		drv_rpm = '0;
		drv_dac = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		push_cmd(REQ_SET, 16'd500, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_START, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
		push_cmd(REQ_SET, 16'd0, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_SET, 16'd50, 1'b1, 1'b1, 16'hFFFF);
		push_cmd(REQ_SET, 16'hFFFF, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_SET, 16'd1234, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_POLL, 16'h0000, 1'b0, 1'b1, 16'hFFFF);
		push_cmd(REQ_POLL, 16'hFFFF, 1'b0, 1'b0, 16'h5555);
		push_cmd(REQ_POLL, 16'h0000, 1'b1, 1'b1, 16'h0000);
		push_cmd(REQ_START, 16'h0000, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_SET, 16'd800, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_STOP, 16'h0000, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_CLEAR, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
		push_cmd(REQ_START, 16'h0000, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_SET, 16'd1999, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_SET, 16'd2000, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_SPARE_LO, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
		push_cmd(REQ_SPARE_LO + 3'd1, 16'h0000, 1'b1, 1'b1, 16'h1234);
		push_cmd(REQ_SPARE_HI, 16'hAAAA, 1'b1, 1'b1, 16'hAAAA);
		push_cmd(REQ_STOP, 16'h0000, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_SET, 16'd700, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_START, 16'h0000, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_SET, 16'd1, 1'b0, 1'b0, 16'h0000);
		push_cmd(REQ_CLEAR, 16'h0000, 1'b0, 1'b0, 16'h0000);
		wait_idle();

		for (int phase = 1; phase <= 8; phase++) begin
			case (phase)
				1: apply_settings(16'd1, 16'd1, 16'd1, 16'd0, 16'd0);
				2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: apply_settings(16'd1000, 16'd0, 16'd4095, 16'd3000, 16'd50);
				4: apply_settings(16'd100, 16'd3300, 16'd4095, 16'd500, 16'd1000);
				5: apply_settings(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0);
				6: apply_settings(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
					16'($urandom_range(65535, 1)), 16'($urandom_range(65535)),
					16'($urandom_range(65535)));
				7: apply_settings(16'd250, 16'd5000, 16'hFFFF, 16'd1, 16'd0);
				default: apply_settings(RST_SENSE, RST_VREF_FS, RST_DAC_FULL, RST_CUR_MAX,
					RST_CUR_MIN);
			endcase
			case ((phase - 1) % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 79;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 79;
				end
				default: begin
					send_idle_pct = 23;
					recv_stall_pct = 23;
				end
			endcase
			queued_count = 0;
			push_cmd(REQ_START, 16'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
			push_cmd(REQ_SET, 16'd0, 1'($urandom), 1'($urandom), 16'($urandom));
			push_cmd(REQ_SET, 16'd1, 1'($urandom), 1'($urandom), 16'($urandom));
			push_cmd(REQ_SET, 16'hFFFF, 1'($urandom), 1'($urandom), 16'($urandom));
			push_cmd(REQ_SET, 16'(cur_min_ma - 16'd1), 1'($urandom), 1'($urandom),
				16'($urandom));
			while (queued_count < PHASE_ITEMS) random_session();
			wait_idle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("motor_current_command_controller verification clean");
		else
			$display("motor_current_command_controller verification failed");
		$finish;
	end

endmodule
